>>> sv/imd_pkg.sv
`default_nettype none

package imd_pkg;

  // largest matrix order handled
  localparam int unsigned MAX_DIM     = 6;
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;

  // fixed field widths
  localparam int unsigned ELEM_W = 8;
  localparam int unsigned DET_W  = 64;
  localparam int unsigned SIZE_W = 3;

  // derived widths
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned COL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned MASK_W = MAX_DIM;
  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MINOR_DEPTH = 1 << MASK_W;

  typedef logic signed [ELEM_W-1:0] element_t;
  typedef logic [DET_W-1:0]         det_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic negate;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> sv/imd_mac.sv
`default_nettype none

module imd_mac (
  input  logic              clk_i,
  input  imd_pkg::mac_ctrl_t ctrl_i,
  input  imd_pkg::element_t elem_i,
  input  imd_pkg::det_t     minor_i,
  output imd_pkg::det_t     acc_o
);
  import imd_pkg::*;

  logic signed [DET_W+ELEM_W-1:0] prod_w;
  det_t prod_q;
  det_t acc_q;

  // signed product, only the low word is kept (modulo 2^64)
  assign prod_w = $signed(minor_i) * elem_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_w[DET_W-1:0];
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.negate) begin
        acc_q <= acc_q - prod_q;
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> sv/integer_matrix_determinant.sv
`default_nettype none

// Exact determinant of a square signed 8-bit matrix of order 1 to 6. Elements
// arrive in row-major order, one per transfer on the element channel; the
// order comes from cfg_data_i (0 is taken as 1, anything above 6 as 6), and
// every configuration transfer restarts the matrix being loaded. Loading accepts
// one element per cycle. After the last element the block stops taking
// elements and works out the determinant by cofactor expansion with all
// minors kept in a table: the minor over the bottom k rows and a column set is
// built from the minors of k-1 rows already stored. One shared 64x8
// multiply-accumulate unit does all the arithmetic: each term passes through
// the read, multiply and accumulate states, each absent column of a column
// set is skipped in the scan state, and each minor is stored in a state of
// its own. The 64-bit result then waits in an output register; the next
// matrix may be loaded while it waits.
module integer_matrix_determinant (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [imd_pkg::SIZE_W-1:0] cfg_data_i,
  // element input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  imd_pkg::element_t     element_i,
  // determinant output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imd_pkg::det_t         determinant_value_o
);
  import imd_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;  // taking elements
  localparam logic [2:0] ST_SCAN  = 3'd1;  // look at one column, issue reads
  localparam logic [2:0] ST_MUL   = 3'd2;  // element times sub-minor
  localparam logic [2:0] ST_ACC   = 3'd3;  // add or subtract the term
  localparam logic [2:0] ST_STORE = 3'd4;  // minor done, store or deliver

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [DIM_W-1:0]  size_q, size_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  det_t              out_data_q;

  logic              in_fire, cfg_fire;
  logic [CNT_W-1:0]  total;
  logic              load_last;
  logic [DIM_W-1:0]  eff_size;
  logic [DIM_W-1:0]  pop;
  logic [DIM_W-1:0]  row;
  logic [ADDR_W-1:0] elem_addr;
  logic [MASK_W-1:0] sub_mask;
  logic [MASK_W-1:0] full_mask;
  logic              col_set, last_col, out_load, rd_en;

  // matrix store and minor table
  element_t mat_mem [STORE_DEPTH];
  det_t     minor_mem [MINOR_DEPTH];
  element_t elem_rd_q;
  det_t     minor_rd_q;
  logic     sub_zero_q;

  det_t      minor_val;
  det_t      acc;
  mac_ctrl_t mac_ctrl;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = (state_q == ST_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // order clamped into 1..MAX_DIM
  always_comb begin
    if (cfg_data_i == '0) begin
      eff_size = DIM_W'(1);
    end else if (32'(cfg_data_i) > MAX_DIM) begin
      eff_size = DIM_W'(MAX_DIM);
    end else begin
      eff_size = DIM_W'(cfg_data_i);
    end
  end

  assign total     = CNT_W'(size_q) * CNT_W'(size_q);
  assign load_last = (load_cnt_q + CNT_W'(1)) == total;

  // number of columns in the current set gives the row being expanded
  always_comb begin
    pop = '0;
    for (int i = 0; i < MASK_W; i++) begin
      pop = pop + DIM_W'(mask_q[i]);
    end
  end

  assign row       = size_q - pop;
  assign elem_addr = ADDR_W'(row) * ADDR_W'(size_q) + ADDR_W'(col_q);
  assign sub_mask  = mask_q & ~(MASK_W'(1) << col_q);
  assign full_mask = {MASK_W{1'b1}} >> (DIM_W'(MAX_DIM) - size_q);
  assign col_set   = mask_q[col_q];
  assign last_col  = (col_q == COL_W'(size_q - DIM_W'(1)));
  assign rd_en     = (state_q == ST_SCAN) && col_set;

  // element store: written while loading, read during expansion
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mat_mem[load_cnt_q[ADDR_W-1:0]] <= element_i;
    end
    if (rd_en) begin
      elem_rd_q <= mat_mem[elem_addr];
    end
  end

  // minor table, indexed by column set; the empty set is the constant one
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      minor_mem[mask_q] <= acc;
    end
    if (rd_en) begin
      minor_rd_q <= minor_mem[sub_mask];
      sub_zero_q <= (sub_mask == '0);
    end
  end

  assign minor_val = sub_zero_q ? det_t'(1) : minor_rd_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    size_d      = size_q;
    mask_d      = mask_q;
    col_d       = col_q;
    neg_d       = neg_q;
    out_load    = 1'b0;
    mac_ctrl    = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (cfg_fire) begin
          size_d     = eff_size;
          load_cnt_d = '0;
        end else if (in_fire) begin
          if (load_last) begin
            // matrix complete, start with single-column sets
            load_cnt_d     = '0;
            mask_d         = MASK_W'(1);
            col_d          = '0;
            neg_d          = 1'b0;
            mac_ctrl.clear = 1'b1;
            state_d        = ST_SCAN;
          end else begin
            load_cnt_d = load_cnt_q + CNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (col_set) begin
          state_d = ST_MUL;
        end else if (last_col) begin
          state_d = ST_STORE;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.negate = neg_q;
        neg_d           = ~neg_q;
        if (last_col) begin
          state_d = ST_STORE;
        end else begin
          col_d   = col_q + COL_W'(1);
          state_d = ST_SCAN;
        end
      end
      ST_STORE: begin
        if (mask_q == full_mask) begin
          // full column set: this is the determinant
          if (!out_valid_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = ST_LOAD;
          end
        end else begin
          mask_d         = mask_q + MASK_W'(1);
          col_d          = '0;
          neg_d          = 1'b0;
          mac_ctrl.clear = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // output register holds the result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      load_cnt_q  <= '0;
      size_q      <= DIM_W'(1);
      mask_q      <= '0;
      col_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      size_q      <= size_d;
      mask_q      <= mask_d;
      col_q       <= col_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= acc;
    end
  end

  // shared multiply-accumulate unit
  imd_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .elem_i  (elem_rd_q),
    .minor_i (minor_val),
    .acc_o   (acc)
  );

  assign out_valid_o         = out_valid_q;
  assign determinant_value_o = out_data_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import imd_pkg::*;

  // quiet cycles allowed before the run is declared hung: well above the
  // settle pause plus an order-6 computation plus the longest stalls
  localparam int unsigned QUIET_LIMIT   = 6000;
  // pause before a size write and at the end, longer than the order-6 latency
  localparam int unsigned SETTLE_CYCLES = 840;
  localparam int unsigned RANDOM_ITEMS  = 1600;

  // element value styles used for a whole matrix
  typedef enum int {
    FILL_UNIFORM,
    FILL_EXTREME,
    FILL_TINY,
    FILL_CONSTANT
  } fill_style_e;

  // tracks the size register and the elements loaded so far, and holds the
  // determinants still owed by the block
  class det_tracker;
    logic [SIZE_W-1:0] size_reg;
    element_t          store [STORE_DEPTH];
    int unsigned       fill;
    det_t              pending_dets [$];
    int unsigned       faults;
    int unsigned       checked;
    int unsigned       elements;
    int unsigned       size_writes;

    function new();
      size_reg    = 1;
      fill        = 0;
      faults      = 0;
      checked     = 0;
      elements    = 0;
      size_writes = 0;
    endfunction

    // order in use: 0 acts as 1, above the bound acts as the bound
    function int unsigned order();
      int unsigned n;
      n = size_reg;
      if (n < 1) n = 1;
      if (n > MAX_DIM) n = MAX_DIM;
      return n;
    endfunction

    function void load_size(logic [SIZE_W-1:0] v);
      size_reg = v;
      fill     = 0;
      size_writes++;
    endfunction

    // minors over the bottom rows, indexed by column set; a set always
    // indexes above its subsets so one upward sweep suffices
    function det_t cofactor_det(int unsigned n);
      longint      minor [MINOR_DEPTH];
      longint      sum;
      longint      prod;
      bit          negate;
      int unsigned row;
      for (int mask = 0; mask < (1 << n); mask++) begin
        if (mask == 0) begin
          minor[mask] = 1;
        end else begin
          row    = n - $countones(mask);
          sum    = 0;
          negate = 1'b0;
          for (int c = 0; c < n; c++) begin
            if (mask[c]) begin
              prod   = longint'(store[row * n + c]) * minor[mask & ~(1 << c)];
              sum    = negate ? sum - prod : sum + prod;
              negate = !negate;
            end
          end
          minor[mask] = sum;
        end
      end
      return det_t'(minor[(1 << n) - 1]);
    endfunction

    function void note_element(element_t e);
      int unsigned total;
      total = order() * order();
      if (fill >= total) fill = 0;
      store[fill] = e;
      fill++;
      elements++;
      if (fill == total) begin
        fill = 0;
        pending_dets.push_back(cofactor_det(order()));
      end
    endfunction

    function void check_result(det_t got);
      det_t want;
      if (pending_dets.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("tb: determinant %0d with none outstanding", $signed(got));
        return;
      end
      want = pending_dets.pop_front();
      checked++;
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("tb: determinant mismatch, expected %0d (%h) got %0d (%h)",
                   $signed(want), want, $signed(got), got);
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  element_t          element_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  det_t              determinant_value_o;

  det_tracker  tracker = new();
  bit          steady;          // phase with no idling on either side
  bit          result_taken;
  bit          stall_drawn;
  int unsigned ready_wait;
  int unsigned quiet_cycles;
  int unsigned random_sent;

  integer_matrix_determinant dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .element_i          (element_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .determinant_value_o(determinant_value_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: check every transfer against the oldest owed determinant
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(determinant_value_o);
      result_taken = 1'b1;
    end
  end

  // receiver stall: drawn once per result as soon as its valid is seen
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 1'b0;
      stall_drawn  = 1'b0;
    end
    if (out_valid_o && !stall_drawn) begin
      stall_drawn = 1'b1;
      ready_wait  = steady ? 0 : $urandom_range(0, 7);
    end
    if (ready_wait > 0) begin
      out_ready_i <= 1'b0;
      ready_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // wait until every owed determinant has arrived, then let the block settle
  task automatic drain_results();
    while (tracker.pending_dets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // size writes only go out with the block idle
  task automatic write_size(input logic [SIZE_W-1:0] v);
    // the last element transfer is done, so its valid goes low first
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.load_size(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one element transfer, after a random gap unless the phase is steady
  task automatic send_element(input element_t e);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_i  <= e;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_element(e);
  endtask

  function automatic element_t draw_element(fill_style_e style);
    case (style)
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return element_t'(-128);
          1: return element_t'(127);
          2: return element_t'(-1);
          3: return element_t'(1);
          default: return element_t'(0);
        endcase
      end
      FILL_TINY:     return element_t'(int'($urandom_range(0, 4)) - 2);
      FILL_CONSTANT: return element_t'(-128);
      default:       return element_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_elements(input int unsigned count, input fill_style_e style);
    for (int unsigned i = 0; i < count; i++) begin
      send_element(draw_element(style));
      random_sent++;
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] size_val;
    int unsigned       n;
    int unsigned       matrices;
    fill_style_e       style;

    steady = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // order 1 straight out of reset, field extremes
    send_element(element_t'(-128));
    send_element(element_t'(127));
    // size zero acts as order 1
    write_size(0);
    send_element(element_t'(0));
    // order 2 with extreme corners
    write_size(2);
    send_element(element_t'(-128));
    send_element(element_t'(127));
    send_element(element_t'(127));
    send_element(element_t'(-128));
    // size write in the middle of a load throws the partial matrix away
    write_size(2);
    send_element(element_t'(55));
    send_element(element_t'(-77));
    write_size(3);
    send_element(element_t'(-128));
    send_element(element_t'(127));
    send_element(element_t'(0));
    send_element(element_t'(1));
    send_element(element_t'(-1));
    send_element(element_t'(127));
    send_element(element_t'(-128));
    send_element(element_t'(-128));
    send_element(element_t'(127));

    // random phases: a size setting, whole matrices, sometimes a stray tail
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      size_val = $urandom_range(0, 7);
      write_size(size_val);
      steady   = ($urandom_range(0, 3) == 0);
      n        = tracker.order();
      matrices = $urandom_range(1, 4);
      for (int unsigned m = 0; m < matrices; m++) begin
        style = fill_style_e'($urandom_range(0, 5) > 3 ? $urandom_range(1, 3) : 0);
        send_elements(n * n, style);
      end
      if (n > 1 && $urandom_range(0, 3) == 0)
        send_elements($urandom_range(1, n * n - 1), FILL_UNIFORM);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    steady = 1'b0;

    drain_results();

    $display("tb: %0d elements sent, %0d determinants checked, %0d size writes",
             tracker.elements, tracker.checked, tracker.size_writes);
    $display("tb: %0d faults, %0d determinants never returned",
             tracker.faults, tracker.pending_dets.size());
    if (tracker.faults == 0 && tracker.pending_dets.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/imd_pkg.sv
sv/imd_mac.sv
sv/integer_matrix_determinant.sv
tb/testbench.sv
